// File: rtl/ppp_pkg.sv
package ppp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int Q_W       = COORD_W;
  localparam int PIX_W     = 16;
  localparam int EXT_W     = Q_W + PIX_W + 2;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STAGES = Q_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT  = 3'd7;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef logic signed [COORD_W-1:0] coef_t;
  typedef coef_t [2:0][3:0] matrix_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] top;
    logic signed [PIX_W-1:0] left;
    logic [PIX_W-1:0]        hgt;
    logic [PIX_W-1:0]        wid;
  } plane_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t        u;
    div_lane_t        v;
    logic [MAG_W-1:0] d;
    logic             behind;
    logic             dzero;
  } div_item_t;

  // Set up one quotient lane: top part of n * 2^F becomes the first remainder
  function automatic div_lane_t div_init(logic nn, logic dn, logic [MAG_W-1:0] mag,
                                         logic [MAG_W-1:0] d);
    div_lane_t l;
    l.rem = mag >> (Q_W - FRAC_BITS);
    l.low = Q_W'(mag << FRAC_BITS);
    l.q   = '0;
    l.neg = (nn != dn) && (mag != '0);
    l.ovf = (mag >> (Q_W - FRAC_BITS)) >= d;
    return l;
  endfunction

  // One restoring division step: shift in one dividend bit, try subtract
  function automatic div_lane_t div_step(div_lane_t a, logic [MAG_W-1:0] d);
    logic [MAG_W:0] r2;
    div_lane_t      b;
    b   = a;
    r2  = {a.rem, a.low[Q_W-1]};
    b.low = a.low << 1;
    if (r2 >= {1'b0, d}) begin
      b.rem = MAG_W'(r2 - {1'b0, d});
      b.q   = {a.q[Q_W-2:0], 1'b1};
    end else begin
      b.rem = r2[MAG_W-1:0];
      b.q   = {a.q[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

// File: rtl/ppp_mac.sv
module ppp_mac
  import ppp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  matrix_t             coef,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  output logic                out_valid,
  input  logic                out_ready,
  output div_item_t           out_item
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic signed [COORD_W-1:0] pt [3];
  logic signed [PROD_W-1:0]  prod [3][3];
  logic signed [COORD_W-1:0] cst2 [3];
  logic signed [SUM_W-1:0]   sum [3];
  logic behind2, behind3;
  logic [MAG_W-1:0] mag [3];
  logic             sgn [3];

  // Advance a stage when it is empty or the next one moves
  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Capture the point
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pt[0] <= in_x;
      pt[1] <= in_y;
      pt[2] <= in_z;
    end
  end

  // Form the nine products
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(pt[c]);
        end
        cst2[r] <= coef[r][3];
      end
      behind2 <= pt[2][COORD_W-1];
    end
  end

  // Sum each row with the constant column
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int r = 0; r < 3; r++) begin
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
                + (SUM_W'(cst2[r]) <<< FRAC_BITS);
      end
      behind3 <= behind2;
    end
  end

  // Split sums into sign and magnitude
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sgn[r] = sum[r][SUM_W-1];
      mag[r] = sgn[r] ? MAG_W'(-sum[r]) : MAG_W'(sum[r]);
    end
  end

  // Set up both quotient lanes
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      out_item.u      <= div_init(sgn[0], sgn[2], mag[0], mag[2]);
      out_item.v      <= div_init(sgn[1], sgn[2], mag[1], mag[2]);
      out_item.d      <= mag[2];
      out_item.behind <= behind3;
      out_item.dzero  <= (mag[2] == '0);
    end
  end

endmodule

// File: rtl/ppp_div_stage.sv
module ppp_div_stage
  import ppp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      en;
  div_item_t item_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Retire one quotient bit in each lane
  always_comb begin
    item_next   = in_item;
    item_next.u = div_step(in_item.u, in_item.d);
    item_next.v = div_step(in_item.v, in_item.d);
  end

  // Advance the request
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/ppp_fin.sv
module ppp_fin
  import ppp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  plane_t                   plane,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  div_item_t                in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [Q_W-1:0]    out_u,
  output logic signed [Q_W-1:0]    out_v,
  output logic [1:0]               out_status
);

  logic en;
  logic sat_u, sat_v;
  logic signed [Q_W-1:0] val_u, val_v;
  logic signed [EXT_W-1:0] eu, ev, lo_x, hi_x, lo_y, hi_y;
  logic in_plane;
  status_t st;

  assign en       = !out_valid || !out_stall;
  assign in_ready = en;

  // Apply sign and saturate one lane
  function automatic logic [Q_W:0] finish(div_lane_t l);
    logic sat;
    logic [Q_W-1:0] val;
    if (l.neg) begin
      sat = l.ovf || (l.q > {1'b1, {(Q_W-1){1'b0}}});
      val = sat ? {1'b1, {(Q_W-1){1'b0}}} : Q_W'(-l.q);
    end else begin
      sat = l.ovf || l.q[Q_W-1];
      val = sat ? {1'b0, {(Q_W-1){1'b1}}} : l.q;
    end
    return {sat, val};
  endfunction

  always_comb begin
    {sat_u, val_u} = finish(in_item.u);
    {sat_v, val_v} = finish(in_item.v);
    eu   = EXT_W'(val_u);
    ev   = EXT_W'(val_v);
    lo_x = EXT_W'(plane.left) <<< FRAC_BITS;
    lo_y = EXT_W'(plane.top) <<< FRAC_BITS;
    hi_x = (EXT_W'(plane.left) + $signed({{(EXT_W-PIX_W){1'b0}}, plane.wid})) <<< FRAC_BITS;
    hi_y = (EXT_W'(plane.top) + $signed({{(EXT_W-PIX_W){1'b0}}, plane.hgt})) <<< FRAC_BITS;
    in_plane = !sat_u && !sat_v && (eu >= lo_x) && (eu < hi_x) && (ev >= lo_y) && (ev < hi_y);
    priority if (in_item.behind) st = ST_BEHIND;
    else if (in_item.dzero)      st = ST_OUTSIDE;
    else if (in_plane)           st = ST_INSIDE;
    else                         st = ST_OUTSIDE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_status <= st;
      if (in_item.behind || in_item.dzero) begin
        out_u <= '0;
        out_v <= '0;
      end else begin
        out_u <= val_u;
        out_v <= val_v;
      end
    end
  end

endmodule

// File: rtl/pinhole_point_projection.sv
// Channel  | Direction | Handshake            | Payload
// point    | in        | point_valid/stall    | point_x, point_y, point_z
// proj     | out       | proj_valid/stall     | proj_u, proj_v, status
// cfg      | in        | cfg_write            | cfg_index, cfg_data
//
// One point enters per cycle while point_stall is low; the stages are capture, products,
// row sums and divisor setup, then the bit-per-stage divider, then the output register.
// The 32 restoring divider stages set the latency.
// rst is synchronous and clears the valid bits and the matrix and plane registers.
// A stall on proj holds the output; upstream stages keep filling bubbles.
module pinhole_point_projection
  import ppp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      point_valid,
  output logic                      point_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  output logic                      proj_valid,
  input  logic                      proj_stall,
  output logic signed [Q_W-1:0]     proj_u,
  output logic signed [Q_W-1:0]     proj_v,
  output logic [1:0]                status
);

  logic [CFG_W-1:0] proj_regs [6];
  logic [2*PIX_W-1:0] plane_origin, plane_extent;
  matrix_t coef;
  plane_t  plane;
  logic    mac_ready;

  div_item_t stage_item  [DIV_STAGES+1];
  logic      stage_valid [DIV_STAGES+1];
  logic      stage_ready [DIV_STAGES+1];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) proj_regs[i] <= '0;
      plane_origin <= '0;
      plane_extent <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW0_01: proj_regs[0] <= cfg_data;
        REG_ROW0_23: proj_regs[1] <= cfg_data;
        REG_ROW1_01: proj_regs[2] <= cfg_data;
        REG_ROW1_23: proj_regs[3] <= cfg_data;
        REG_ROW2_01: proj_regs[4] <= cfg_data;
        REG_ROW2_23: proj_regs[5] <= cfg_data;
        REG_ORIGIN:  plane_origin <= cfg_data[2*PIX_W-1:0];
        REG_EXTENT:  plane_extent <= cfg_data[2*PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficients and rectangle
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = proj_regs[2*r][COORD_W-1:0];
      coef[r][1] = proj_regs[2*r][2*COORD_W-1:COORD_W];
      coef[r][2] = proj_regs[2*r+1][COORD_W-1:0];
      coef[r][3] = proj_regs[2*r+1][2*COORD_W-1:COORD_W];
    end
    plane.left = plane_origin[PIX_W-1:0];
    plane.top  = plane_origin[2*PIX_W-1:PIX_W];
    plane.wid  = plane_extent[PIX_W-1:0];
    plane.hgt  = plane_extent[2*PIX_W-1:PIX_W];
  end

  assign point_stall = !mac_ready;

  ppp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (point_valid),
    .in_ready  (mac_ready),
    .in_x      (point_x),
    .in_y      (point_y),
    .in_z      (point_z),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_item[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ppp_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  ppp_fin u_fin (
    .clk        (clk),
    .rst        (rst),
    .plane      (plane),
    .in_valid   (stage_valid[DIV_STAGES]),
    .in_ready   (stage_ready[DIV_STAGES]),
    .in_item    (stage_item[DIV_STAGES]),
    .out_valid  (proj_valid),
    .out_stall  (proj_stall),
    .out_u      (proj_u),
    .out_v      (proj_v),
    .out_status (status)
  );

endmodule

// File: rtl/ppp_checker.sv
module ppp_checker
  import ppp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  proj_valid,
  input logic                  proj_stall,
  input logic signed [Q_W-1:0] proj_u,
  input logic signed [Q_W-1:0] proj_v,
  input logic [1:0]            status
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !proj_valid)
    else $error("result present after reset");

  // Status code is one of the three defined values
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    proj_valid |-> (status == ST_INSIDE || status == ST_BEHIND || status == ST_OUTSIDE))
    else $error("undefined status code");

  // A point behind the camera carries zero coordinates
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    proj_valid && status == ST_BEHIND |-> proj_u == '0 && proj_v == '0)
    else $error("behind point with nonzero coordinates");

  // Stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    proj_valid && proj_stall |=> proj_valid && $stable(proj_u) && $stable(proj_v)
      && $stable(status))
    else $error("stalled result changed");

endmodule

bind pinhole_point_projection ppp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .proj_valid (proj_valid),
  .proj_stall (proj_stall),
  .proj_u     (proj_u),
  .proj_v     (proj_v),
  .status     (status)
);

// File: tb/pinhole_point_projection_tb.sv
`timescale 1ns / 100ps

module pinhole_point_projection_tb;
  import ppp_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct {
    logic signed [Q_W-1:0] u;
    logic signed [Q_W-1:0] v;
    status_t               st;
  } pixel_t;

  localparam int ONE = 1 << FRAC_BITS;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      point_valid = 1'b0;
  logic                      point_stall;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      proj_valid;
  logic                      proj_stall = 1'b0;
  logic signed [Q_W-1:0]     proj_u;
  logic signed [Q_W-1:0]     proj_v;
  logic [1:0]                status;

  // Local copy of the matrix and plane
  logic signed [COORD_W-1:0] coefs [3][4];
  logic [31:0]               origin_r;
  logic [31:0]               extent_r;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     took = 1'b0;

  pinhole_point_projection u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_valid(point_valid), .point_stall(point_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .proj_valid(proj_valid), .proj_stall(proj_stall),
    .proj_u(proj_u), .proj_v(proj_v), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Exact row sum of P[r] * (x, y, z, 1)
  function automatic logic signed [67:0] row_sum(int r, point_t p);
    logic signed [67:0] k0, k1, k2, k3, px, py, pz;
    k0 = coefs[r][0];
    k1 = coefs[r][1];
    k2 = coefs[r][2];
    k3 = coefs[r][3];
    px = p.x;
    py = p.y;
    pz = p.z;
    return k0 * px + k1 * py + k2 * pz + (k3 <<< FRAC_BITS);
  endfunction

  // Truncated n * 2^F / d, saturated to 32 bits; bit 32 flags saturation
  function automatic logic [32:0] quotient(logic signed [67:0] n, logic signed [67:0] d);
    logic [95:0] nm, dm, q;
    logic        neg;
    nm  = n < 0 ? 96'(-n) : 96'(n);
    dm  = d < 0 ? 96'(-d) : 96'(d);
    q   = (nm << FRAC_BITS) / dm;
    neg = ((n < 0) != (d < 0)) && (nm != 0);
    if (neg) begin
      if (q > 96'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-q)};
    end
    if (q > 96'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[31:0]};
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t             px;
    logic signed [67:0] s0, s1, s2;
    logic [32:0]        qu, qv;
    logic signed [63:0] left, top, wid, hgt, u64, v64;
    px.u  = '0;
    px.v  = '0;
    px.st = ST_BEHIND;
    if (p.z < 0) return px;
    s0 = row_sum(0, p);
    s1 = row_sum(1, p);
    s2 = row_sum(2, p);
    px.st = ST_OUTSIDE;
    if (s2 == 0) return px;
    qu   = quotient(s0, s2);
    qv   = quotient(s1, s2);
    px.u = qu[31:0];
    px.v = qv[31:0];
    left = $signed(origin_r[15:0]);
    top  = $signed(origin_r[31:16]);
    wid  = {48'b0, extent_r[15:0]};
    hgt  = {48'b0, extent_r[31:16]};
    u64  = px.u;
    v64  = px.v;
    if (!qu[32] && !qv[32] && u64 >= left * ONE && u64 < (left + wid) * ONE &&
        v64 >= top * ONE && v64 < (top + hgt) * ONE)
      px.st = ST_INSIDE;
    return px;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_ORIGIN) begin
      origin_r = data[31:0];
    end else if (idx == REG_EXTENT) begin
      extent_r = data[31:0];
    end else begin
      coefs[idx / 2][(idx % 2) * 2]     = data[31:0];
      coefs[idx / 2][(idx % 2) * 2 + 1] = data[63:32];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] m [3][4]);
    write_reg(REG_ROW0_01, {m[0][1], m[0][0]});
    write_reg(REG_ROW0_23, {m[0][3], m[0][2]});
    write_reg(REG_ROW1_01, {m[1][1], m[1][0]});
    write_reg(REG_ROW1_23, {m[1][3], m[1][2]});
    write_reg(REG_ROW2_01, {m[2][1], m[2][0]});
    write_reg(REG_ROW2_23, {m[2][3], m[2][2]});
  endtask

  task automatic push_point(int x, int y, int z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points = {pending_points, p};
  endtask

  // Mostly points in front of a camera, some behind, some raw bit noise
  task automatic push_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 55)
        push_point(int'($urandom_range(0, 40 * ONE)) - 20 * ONE,
                   int'($urandom_range(0, 40 * ONE)) - 20 * ONE,
                   int'($urandom_range(ONE / 2, 50 * ONE)));
      else if (sel < 65)
        push_point($urandom, $urandom, -int'($urandom_range(1, 1 << 24)));
      else if (sel < 70)
        push_point($urandom, $urandom, 0);
      else
        push_point($urandom, $urandom, $urandom);
    end
  endtask

  // Wait until every request is answered, then let the pipeline empty
  task automatic drain();
    while (pending_points.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic set_idling(int phase);
    if (phase < 2) begin
      send_idle_pct = 7;
      recv_idle_pct = 74;
    end else if (phase < 4) begin
      send_idle_pct = 74;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Sender: hold a stalled request, otherwise advance or idle
  always @(negedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || took) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        point_valid <= 1'b1;
        point_x     <= pending_points[0].x;
        point_y     <= pending_points[0].y;
        point_z     <= pending_points[0].z;
      end else begin
        point_valid <= 1'b0;
      end
    end
    proj_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
  end

  // Accept requests into the predictor, check results against it
  always @(posedge clk) begin
    pixel_t want;
    point_t sent;
    took = 1'b0;
    if (!rst && point_valid && !point_stall) begin
      took = 1'b1;
      sent = pending_points.pop_front();
      expected_pixels = {expected_pixels, project_point(sent)};
    end
    if (!rst && proj_valid && !proj_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result u=%0h v=%0h", $realtime, proj_u, proj_v);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (proj_u !== want.u) report_mismatch("proj_u", proj_u, want.u);
        if (proj_v !== want.v) report_mismatch("proj_v", proj_v, want.v);
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
  end

  initial begin
    logic [31:0] cam [3][4];
    logic [31:0] m [3][4];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) coefs[r][c] = '0;
    origin_r = '0;
    extent_r = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset matrix: every divisor is zero
    set_idling(0);
    push_point(ONE, ONE, ONE);
    push_point(0, 0, 0);
    push_point(0, 0, -1);
    push_random(30);
    drain();

    // Camera: f = 500 px, center (320, 240), 640 x 480 plane
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) cam[r][c] = '0;
    cam[0][0] = 500 * ONE;
    cam[0][2] = 320 * ONE;
    cam[1][1] = 500 * ONE;
    cam[1][2] = 240 * ONE;
    cam[2][2] = ONE;
    load_matrix(cam);
    write_reg(REG_ORIGIN, 64'h0);
    write_reg(REG_EXTENT, {32'h0, 16'd480, 16'd640});
    set_idling(1);
    push_point(0, 0, ONE);                         // center pixel
    push_point(0, 0, 0);                           // z = 0 gives zero divisor
    push_point(0, 0, -1);                          // just behind
    push_point(0, 0, 32'h8000_0000);               // far behind
    push_point(0, 0, 32'h7FFF_FFFF);               // farthest ahead
    push_point(-(320 * ONE) / 500, -(240 * ONE) / 500, ONE);  // near top-left corner
    push_point(-ONE * 64 / 100, 0, ONE);           // left edge, u just above 0
    push_point(ONE * 64 / 100, 0, ONE);            // right edge, u just below 640
    push_point(0, ONE * 48 / 100, ONE);            // bottom edge, v just below 480
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);   // saturates high
    push_point(32'h8000_0000, 32'h8000_0000, 1);   // saturates low
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, ONE);
    push_point(ONE, -ONE, 10 * ONE);
    push_random(300);
    drain();

    // Negative plane origin, widest plane
    write_reg(REG_ORIGIN, {32'h0, 16'hFF38, 16'hFF9C});
    write_reg(REG_EXTENT, {32'h0, 16'hFFFF, 16'hFFFF});
    set_idling(2);
    push_random(250);
    drain();

    // Random matrix and plane
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) m[r][c] = $urandom;
    load_matrix(m);
    write_reg(REG_ORIGIN, {32'h0, $urandom});
    write_reg(REG_EXTENT, {32'h0, $urandom});
    set_idling(3);
    push_random(250);
    drain();

    // Extreme coefficients
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) m[r][c] = ((r + c) % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    load_matrix(m);
    write_reg(REG_ORIGIN, {32'h0, 16'h8000, 16'h7FFF});
    write_reg(REG_EXTENT, {32'h0, 16'h0, 16'h0});
    set_idling(4);
    push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_point(32'h8000_0000, 32'h8000_0000, 0);
    push_random(200);
    drain();

    // Camera again, zero-width plane and then a small offset plane
    load_matrix(cam);
    write_reg(REG_ORIGIN, {32'h0, 16'd0, 16'd0});
    write_reg(REG_EXTENT, {32'h0, 16'd480, 16'd0});
    set_idling(5);
    push_random(150);
    drain();
    write_reg(REG_ORIGIN, {32'h0, 16'd100, 16'd200});
    write_reg(REG_EXTENT, {32'h0, 16'd100, 16'd100});
    set_idling(5);
    push_random(170);
    drain();

    if (errors == 0)
      $display("pinhole_point_projection_tb passed");
    else
      $display("pinhole_point_projection_tb failed");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("pinhole_point_projection_tb failed");
    $finish;
  end

endmodule
